// ===== rtl/nur_cache_replacement_defines.svh =====
// Assertion macros for the not-used-recently replacement block.
// Used by nur_cache_replacement.sv; assumes i_clk and i_rst_n in scope.
`ifndef NUR_CACHE_REPLACEMENT_DEFINES_SVH
`define NUR_CACHE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NUR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NUR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nur_pkg.sv =====
// Package for the not-used-recently replacement block: request and result
// types, operation codes, sequencer states and fixed constants. No dependencies.
package nur_pkg;

    // Operation codes of a request
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_REPLACE = 2'd2
    } t_op;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] block_index;
    } t_req;

    typedef struct packed {
        logic [3:0] victim_index;
        logic       victim_was_free;
        logic [1:0] victim_class;
    } t_result;

    localparam int unsigned PERIOD_W           = 16;
    localparam logic [PERIOD_W-1:0] DEREF_PERIOD_RESET = 16'd1000;
    // Class tracker value meaning "no block seen yet"
    localparam logic [2:0]  CLASS_NONE         = 3'd4;

endpackage

// ===== rtl/nur_cache_replacement.sv =====
// Not-used-recently victim selection over NUM_BLOCKS cache blocks.
// Depends on nur_pkg and nur_cache_replacement_defines.svh.
//
// Usage:
//   A request (i_req: operation, block_index) is taken at a clock edge with
//   start high and busy low. A read sets the block's referenced bit, a write
//   sets referenced and modified; busy stays low for both.
//   Every in-range access counts down the dereference period; when it runs
//   out all referenced bits clear and the count reloads from the period
//   register (a zero period reloads as one).
//   A replace request raises busy and walks the blocks one per cycle through
//   one shared compare unit; the last step also marks the chosen block valid
//   with clear bits. The result appears on o_res with o_valid high for
//   exactly one cycle right after busy falls. Reads, writes and the undefined
//   operation produce no result. The period register is written with
//   i_cfg_we / i_cfg_wdata; the user must write it only while idle, which the
//   block does not enforce. It takes effect at the next reload.
//   Reset clears all block bits, loads the period and the countdown with
//   1000 and drops busy. Results cannot be stalled by the receiver.
module nur_cache_replacement #(
    parameter int unsigned NUM_BLOCKS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nur_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [nur_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    output logic                          o_valid,
    output nur_pkg::t_result              o_res
);
    import nur_pkg::*;

`include "nur_cache_replacement_defines.svh"

    localparam int unsigned IDX_W  = $clog2(NUM_BLOCKS);
    localparam int unsigned WIDE_W = IDX_W + 4;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [WIDE_W-1:0] NUM_WIDE  = WIDE_W'(NUM_BLOCKS);

    t_state                r_state, n_state;
    logic [NUM_BLOCKS-1:0] r_valid, n_valid;
    logic [NUM_BLOCKS-1:0] r_ref, n_ref;
    logic [NUM_BLOCKS-1:0] r_mod, n_mod;
    logic [PERIOD_W-1:0]   r_period;
    logic [PERIOD_W-1:0]   r_countdown, n_countdown;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_pick, n_pick;
    logic [2:0]            r_best, n_best;
    logic                  r_found, n_found;
    logic                  r_out_valid, n_out_valid;
    t_result               r_res, n_res;

    logic                  take;
    logic                  scan_en;
    logic                  last_step;
    logic [WIDE_W-1:0]     acc_wide;
    logic [IDX_W-1:0]      acc_idx;
    logic                  acc_in_range;
    logic [WIDE_W-1:0]     pick_wide;

    assign take         = start && !busy;
    assign acc_wide     = {{IDX_W{1'b0}}, i_req.block_index};
    assign acc_idx      = acc_wide[IDX_W-1:0];
    assign acc_in_range = acc_wide < NUM_WIDE;
    assign last_step    = (r_cnt == LAST_IDX);

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_req.operation == OP_REPLACE) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        busy    = 1'b0;
        scan_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                scan_en = 1'b0;
            end
            ST_SCAN: begin
                busy    = 1'b1;
                scan_en = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                scan_en = 1'b0;
            end
        endcase
    end

    // Datapath: accesses, countdown, and one block compare per scan cycle
    always_comb begin
        logic [NUM_BLOCKS-1:0] set_mask;
        logic [2:0]            cls;
        logic                  blk_valid;

        set_mask    = '0;
        cls         = {1'b0, r_ref[r_cnt], r_mod[r_cnt]};
        blk_valid   = r_valid[r_cnt];

        n_valid     = r_valid;
        n_ref       = r_ref;
        n_mod       = r_mod;
        n_countdown = r_countdown;
        n_cnt       = r_cnt;
        n_pick      = r_pick;
        n_best      = r_best;
        n_found     = r_found;
        n_out_valid = 1'b0;
        n_res       = r_res;
        pick_wide   = '0;

        // Read or write access: set bits, then count down
        if (take && (i_req.operation == OP_READ || i_req.operation == OP_WRITE)
            && acc_in_range) begin
            set_mask[acc_idx] = 1'b1;
            n_ref = r_ref | set_mask;
            if (i_req.operation == OP_WRITE) begin
                n_mod = r_mod | set_mask;
            end
            if (r_countdown > PERIOD_W'(1)) begin
                n_countdown = r_countdown - PERIOD_W'(1);
            end else begin
                n_ref       = '0;
                n_countdown = (r_period == '0) ? PERIOD_W'(1) : r_period;
            end
        end

        // Replace request: arm the scan
        if (take && i_req.operation == OP_REPLACE) begin
            n_cnt   = '0;
            n_pick  = '0;
            n_best  = CLASS_NONE;
            n_found = 1'b0;
        end

        // Scan step: first free block wins, else first of lowest class
        if (scan_en) begin
            if (!r_found && !blk_valid) begin
                n_found = 1'b1;
                n_pick  = r_cnt;
            end else if (!r_found && cls < r_best) begin
                n_best = cls;
                n_pick = r_cnt;
            end
            n_cnt = r_cnt + IDX_W'(1);

            // Last step: claim the victim and register the result
            if (last_step) begin
                n_cnt           = '0;
                n_valid[n_pick] = 1'b1;
                n_ref[n_pick]   = 1'b0;
                n_mod[n_pick]   = 1'b0;
                pick_wide       = {4'b0, n_pick};
                n_res.victim_index    = pick_wide[3:0];
                n_res.victim_was_free = n_found;
                n_res.victim_class    = n_found ? 2'b00 : n_best[1:0];
                n_out_valid     = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_ref       <= '0;
            r_mod       <= '0;
            r_period    <= DEREF_PERIOD_RESET;
            r_countdown <= DEREF_PERIOD_RESET;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_ref       <= n_ref;
            r_mod       <= n_mod;
            r_countdown <= n_countdown;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        r_best <= n_best;
        r_res  <= n_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // Result strobe only right after a scan ends
    `NUR_ASSERT_NOW(a_strobe_after_scan, o_valid, $past(r_state == ST_SCAN),
        "result strobe without a finished scan")

    // Victim block is valid and clean when its result is shown
    `NUR_ASSERT_NOW(a_victim_claimed, o_valid,
        r_valid[r_pick] && !r_ref[r_pick] && !r_mod[r_pick],
        "victim block not claimed")

    // Scan keeps busy until the last block is examined
    `NUR_ASSERT_NEXT(a_scan_holds, r_state == ST_SCAN && !last_step,
        r_state == ST_SCAN && busy, "scan ended early")

endmodule

// ===== dv/testbench.sv =====
// Testbench for nur_cache_replacement: directed and random request streams,
// with each victim checked against a shadow model of not-used-recently selection.
// Depends on nur_pkg and the nur_cache_replacement RTL.
module testbench;
    import nur_pkg::*;

    localparam int NUM_BLOCKS    = 16;
    localparam logic [1:0] OP_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = NUM_BLOCKS + 4;
    localparam int REPORT_LIMIT  = 10;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    t_req                i_req       = '0;
    logic                i_cfg_we    = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wdata = '0;
    logic                o_valid;
    t_result             o_res;

    // Shadow copy of the block bits, the period register and the countdown
    logic [NUM_BLOCKS-1:0] valid_map  = '0;
    logic [NUM_BLOCKS-1:0] ref_map    = '0;
    logic [NUM_BLOCKS-1:0] mod_map    = '0;
    logic [PERIOD_W-1:0]   deref_period = DEREF_PERIOD_RESET;
    logic [PERIOD_W-1:0]   deref_count  = DEREF_PERIOD_RESET;

    t_result pending_victims[$];
    int      error_count = 0;
    int      cycle_count = 0;

    nur_cache_replacement #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nur_cache_replacement test failed");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0d] %s", cycle_count, msg);
        end
    endtask

    // Update the shadow state for one accepted request; queue the victim on a replace
    task automatic track_request(input t_req req);
        int         pick;
        logic [2:0] best;
        logic [2:0] cls;
        logic       found_free;
        t_result    victim;
        pick       = 0;
        best       = CLASS_NONE;
        found_free = 1'b0;
        case (req.operation)
            OP_READ, OP_WRITE: begin
                if (req.block_index < NUM_BLOCKS) begin
                    ref_map[req.block_index] = 1'b1;
                    if (req.operation == OP_WRITE) begin
                        mod_map[req.block_index] = 1'b1;
                    end
                    // Count down after setting the bits; expiry clears every R bit
                    if (deref_count > 1) begin
                        deref_count = deref_count - 1'b1;
                    end else begin
                        ref_map     = '0;
                        deref_count = (deref_period == '0) ? PERIOD_W'(1) : deref_period;
                    end
                end
            end
            OP_REPLACE: begin
                // Lowest free block first, else first block of lowest 2R+M class
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (!valid_map[i] && !found_free) begin
                        pick       = i;
                        found_free = 1'b1;
                    end
                end
                if (!found_free) begin
                    for (int i = 0; i < NUM_BLOCKS; i++) begin
                        cls = {1'b0, ref_map[i], mod_map[i]};
                        if (cls < best) begin
                            best = cls;
                            pick = i;
                        end
                    end
                end
                valid_map[pick] = 1'b1;
                ref_map[pick]   = 1'b0;
                mod_map[pick]   = 1'b0;
                victim.victim_index    = 4'(pick);
                victim.victim_was_free = found_free;
                victim.victim_class    = found_free ? 2'd0 : best[1:0];
                pending_victims.push_back(victim);
            end
            default: begin
                // Undefined operation: no effect
            end
        endcase
    endtask

    // Compare each result against the oldest expected victim
    always @(posedge i_clk) begin : check_victims
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_victims.size() == 0) begin
                note_failure($sformatf("unexpected result: index %0d free %0d class %0d",
                    o_res.victim_index, o_res.victim_was_free, o_res.victim_class));
            end else begin
                want = pending_victims.pop_front();
                if (o_res.victim_index !== want.victim_index ||
                    o_res.victim_was_free !== want.victim_was_free ||
                    o_res.victim_class !== want.victim_class) begin
                    note_failure($sformatf(
                        "victim mismatch: expected index %0d free %0d class %0d, got %0d %0d %0d",
                        want.victim_index, want.victim_was_free, want.victim_class,
                        o_res.victim_index, o_res.victim_was_free, o_res.victim_class));
                end
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [1:0] op, input logic [3:0] index);
        t_req req;
        req.operation   = op;
        req.block_index = index;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        track_request(req);
    endtask

    // Drop start, wait for all victims, then let the block go quiet
    task automatic settle_block();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_victims.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Accesses to invalid blocks, the undefined operation, fill, then an eviction
    task automatic test_directed_fill_and_evict();
        send_request(OP_WRITE, 4'd15);
        send_request(OP_READ, 4'd3);
        send_request(OP_UNDEFINED, 4'd15);
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            send_request(OP_REPLACE, 4'(i));
        end
        send_request(OP_READ, 4'd0);
        send_request(OP_WRITE, 4'd1);
        send_request(OP_WRITE, 4'd2);
        send_request(OP_REPLACE, 4'd0);
    endtask

    // Random traffic under one dereference period
    task automatic test_deref_period(input logic [PERIOD_W-1:0] period, input int n_items,
                                     input int idle_pct);
        int         sent;
        int         pick;
        logic [1:0] op;
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= period;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        deref_period = period;
        sent = 0;
        while (sent < n_items) begin
            // Hold off the sender for a random gap
            if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(18, 1)) @(posedge i_clk);
            end
            // Now and then, wait for every outstanding victim
            if ($urandom_range(63) == 0 && pending_victims.size() != 0) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending_victims.size() != 0);
            end
            pick = $urandom_range(99);
            if (pick < 40) begin
                op = OP_READ;
            end else if (pick < 65) begin
                op = OP_WRITE;
            end else if (pick < 95) begin
                op = OP_REPLACE;
            end else begin
                op = OP_UNDEFINED;
            end
            send_request(op, 4'($urandom_range(NUM_BLOCKS - 1)));
            if (op != OP_UNDEFINED) begin
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_fill_and_evict();
        test_deref_period(16'd3, 150, 23);
        test_deref_period(16'd1, 150, 23);
        test_deref_period(16'hFFFF, 150, 49);
        test_deref_period(16'd0, 150, 49);
        test_deref_period(16'd7, 150, 0);
        test_deref_period(DEREF_PERIOD_RESET, 150, 0);
        settle_block();
        if (error_count == 0) begin
            $display("nur_cache_replacement test passed");
        end else begin
            $display("nur_cache_replacement test failed");
        end
        $finish;
    end

endmodule
